/* hw/rtl/dsm_pkg.sv */
// Shared constants, types and helpers of the decimal string multiplier.
package dsm_pkg;

  localparam int unsigned MAX_DIGITS_DEF = 32;
  localparam int unsigned DIGIT_W        = 4;
  localparam int unsigned SUM_W          = 13;  // column sum width
  localparam int unsigned PROD_W         = 8;   // digit by digit product

  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
  localparam logic [DIGIT_W-1:0] DIGIT_ZERO = 4'd0;
  localparam logic [SUM_W-1:0]   RADIX     = 13'd10;

  localparam logic CMD_FIRST  = 1'b0;
  localparam logic CMD_SECOND = 1'b1;

  // Operation on the column memory, issued together with its address.
  typedef enum logic [2:0] {
    COL_IDLE,
    COL_CLEAR,
    COL_ACC,
    COL_RIPPLE,
    COL_READ
  } col_op_e;

  typedef struct packed {
    col_op_e op;
    logic    first;  // first column of the carry ripple: carry in is zero
    logic    msb;    // column 0: keeps its full value
  } col_cmd_t;

  typedef struct packed {
    logic                en;
    logic                sel;
    logic [DIGIT_W-1:0]  digit;
  } opnd_wr_t;

  typedef struct packed {
    logic first_zero;   // first stored digit of operand one is 0
    logic second_zero;  // first stored digit of operand two is 0
    logic overflow;     // a digit was dropped since the last run
  } opnd_stat_t;

  // Quotient by ten through the reciprocal 6554 / 2^16, exact below 8192.
  function automatic logic [SUM_W-1:0] div10(input logic [SUM_W-1:0] x);
    logic [31:0] p;
    p = 32'(x) * 32'd6554;
    return p[SUM_W+15:16];
  endfunction

endpackage

/* hw/rtl/dsm_stream_if.sv */
// Valid/ready channels for digit input and product output.
interface dsm_in_if import dsm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               command;
  logic [DIGIT_W-1:0] digit;
  logic               final_digit;

  modport source (output valid, command, digit, final_digit, input ready);
  modport sink (input valid, command, digit, final_digit, output ready);
endinterface

interface dsm_out_if import dsm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] product_digit;
  logic               last_digit;
  logic               too_long;

  modport source (output valid, product_digit, last_digit, too_long, input ready);
  modport sink (input valid, product_digit, last_digit, too_long, output ready);
endinterface

/* hw/rtl/decimal_string_multiplier.sv */
// Top level of the decimal string multiplier: control sequencer and channels.
//
// Operand digits arrive most significant first, one transfer per cycle while
// in_i.ready is high; command picks the operand, final_digit on the last digit
// starts the product and drops ready until the last product digit has been
// taken. Digits above nine are stored as nine; digits beyond MAX_DIGITS per
// operand are dropped and reported through too_long on every digit of that
// run. A product run walks one column memory (2*MAX_DIGITS sums, one read and
// one write port): a zero check, a clear of the len1+len2 columns, digit
// product accumulation (one column read-modify-write per cycle, forwarded
// when consecutive updates hit the same column), the carry ripple, a drain
// step and a step that settles the leading zero, then a read, a load and an
// output transfer per product digit, the transfer waiting out any output
// stall. An empty or single zero operand answers with one digit 0 after the check.
module decimal_string_multiplier import dsm_pkg::*; #(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  dsm_in_if.sink     in_i,
  dsm_out_if.source  out_o
);

  localparam int unsigned AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned LW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned CW = $clog2(2 * MAX_DIGITS);
  localparam int unsigned TW = $clog2(2 * MAX_DIGITS + 1);

  typedef enum logic [3:0] {
    S_LOAD,      // taking operand digits
    S_CHECK,     // zero / empty operand test
    S_CLEAR,     // zero the column sums
    S_ACC,       // accumulate digit products
    S_RIPPLE,    // carry ripple, least significant column first
    S_DRAIN,     // last ripple write in flight
    S_START,     // skip one leading zero
    S_EMIT_RD,   // read a product column
    S_EMIT_LD,   // load output register
    S_EMIT_OUT   // wait for the output transfer
  } state_e;

  state_e             state_q;
  logic [AW-1:0]      i_q, j_q;
  logic [CW-1:0]      k_q;
  logic [TW-1:0]      total_q;
  logic               flag_q;
  logic               out_valid_q;
  logic [DIGIT_W-1:0] out_digit_q;
  logic               out_last_q;

  logic               in_xfer, out_xfer;
  opnd_wr_t           opnd_wr;
  logic               opnd_clr;
  logic               opnd_rd;
  logic [DIGIT_W-1:0] a_digit, b_digit;
  logic [LW-1:0]      len1, len2;
  opnd_stat_t         opnd_stat;
  col_cmd_t           col_cmd;
  logic [CW-1:0]      col_addr;
  logic [PROD_W-1:0]  prod;
  logic [DIGIT_W-1:0] col_digit;
  logic               col_lead_zero;

  logic               zero_run, last_col, i_last, j_last;

  assign in_i.ready = (state_q == S_LOAD);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_xfer   = out_o.valid && out_o.ready;

  assign opnd_wr.en    = in_xfer;
  assign opnd_wr.sel   = in_i.command;
  assign opnd_wr.digit = in_i.digit;
  assign opnd_clr      = (state_q == S_EMIT_OUT) && out_xfer && out_last_q;
  assign opnd_rd       = (state_q == S_ACC);

  assign zero_run = (len1 == '0) || (len2 == '0) ||
                    ((len1 == LW'(1)) && opnd_stat.first_zero) ||
                    ((len2 == LW'(1)) && opnd_stat.second_zero);
  assign last_col = (TW'(k_q) + TW'(1)) == total_q;
  assign i_last   = (LW'(i_q) + LW'(1)) == len1;
  assign j_last   = (LW'(j_q) + LW'(1)) == len2;

  // operand data is registered and arrives in the cycle after the read, aligned with the column data
  assign prod = {{(PROD_W-DIGIT_W){1'b0}}, a_digit} * {{(PROD_W-DIGIT_W){1'b0}}, b_digit};

  always_comb begin
    col_cmd  = '{op: COL_IDLE, first: 1'b0, msb: 1'b0};
    col_addr = k_q;
    unique case (state_q)
      S_CLEAR:   col_cmd.op = COL_CLEAR;
      S_ACC: begin
        col_cmd.op = COL_ACC;
        col_addr   = CW'(i_q) + CW'(j_q) + CW'(1);
      end
      S_RIPPLE: begin
        col_cmd.op    = COL_RIPPLE;
        col_cmd.first = last_col;
        col_cmd.msb   = (k_q == '0);
      end
      S_EMIT_RD: col_cmd.op = COL_READ;
      default:   col_cmd.op = COL_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      total_q     <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_digit_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_LOAD: begin
          if (in_xfer && in_i.final_digit) state_q <= S_CHECK;
        end
        S_CHECK: begin
          flag_q  <= opnd_stat.overflow;
          total_q <= TW'(len1) + TW'(len2);
          k_q     <= '0;
          if (zero_run) begin
            out_valid_q <= 1'b1;
            out_digit_q <= DIGIT_ZERO;
            out_last_q  <= 1'b1;
            state_q     <= S_EMIT_OUT;
          end else begin
            state_q <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          if (last_col) begin
            i_q     <= '0;
            j_q     <= '0;
            state_q <= S_ACC;
          end else begin
            k_q <= k_q + CW'(1);
          end
        end
        S_ACC: begin
          if (j_last) begin
            j_q <= '0;
            if (i_last) begin
              k_q     <= CW'(total_q - TW'(1));
              state_q <= S_RIPPLE;
            end else begin
              i_q <= i_q + AW'(1);
            end
          end else begin
            j_q <= j_q + AW'(1);
          end
        end
        S_RIPPLE: begin
          if (k_q == '0) state_q <= S_DRAIN;
          else k_q <= k_q - CW'(1);
        end
        S_DRAIN: state_q <= S_START;
        S_START: begin
          k_q     <= col_lead_zero ? CW'(1) : '0;
          state_q <= S_EMIT_RD;
        end
        S_EMIT_RD: state_q <= S_EMIT_LD;
        S_EMIT_LD: begin
          out_valid_q <= 1'b1;
          out_digit_q <= col_digit;
          out_last_q  <= last_col;
          state_q     <= S_EMIT_OUT;
        end
        S_EMIT_OUT: begin
          if (out_xfer) begin
            out_valid_q <= 1'b0;
            if (out_last_q) begin
              state_q <= S_LOAD;
            end else begin
              k_q     <= k_q + CW'(1);
              state_q <= S_EMIT_RD;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.product_digit = out_digit_q;
  assign out_o.last_digit    = out_last_q;
  assign out_o.too_long      = flag_q;

  dsm_operand_store #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_opnd (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (opnd_wr),
    .clear_i      (opnd_clr),
    .rd_en_i      (opnd_rd),
    .rd_a_addr_i  (i_q),
    .rd_b_addr_i  (j_q),
    .a_digit_o    (a_digit),
    .b_digit_o    (b_digit),
    .first_len_o  (len1),
    .second_len_o (len2),
    .stat_o       (opnd_stat)
  );

  dsm_column_unit #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_cols (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (col_cmd),
    .addr_i      (col_addr),
    .prod_i      (prod),
    .digit_o     (col_digit),
    .lead_zero_o (col_lead_zero)
  );

  a_load_no_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !out_o.valid)
    else $error("digit load open while a product digit is pending");

  a_acc_operands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC) |-> (len1 != '0) && (len2 != '0))
    else $error("accumulating with an empty operand");

  a_last_reopens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && out_o.last_digit |=> in_i.ready && (len1 == '0) && (len2 == '0))
    else $error("run end did not reopen the digit load");

endmodule

/* hw/rtl/dsm_operand_store.sv */
// Digit memories of both operands with their lengths and flags.
module dsm_operand_store import dsm_pkg::*; #(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF,
  localparam int unsigned AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1,
  localparam int unsigned LW = $clog2(MAX_DIGITS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  opnd_wr_t           wr_i,
  input  logic               clear_i,
  input  logic               rd_en_i,
  input  logic [AW-1:0]      rd_a_addr_i,
  input  logic [AW-1:0]      rd_b_addr_i,
  output logic [DIGIT_W-1:0] a_digit_o,
  output logic [DIGIT_W-1:0] b_digit_o,
  output logic [LW-1:0]      first_len_o,
  output logic [LW-1:0]      second_len_o,
  output opnd_stat_t         stat_o
);

  logic [DIGIT_W-1:0] first_mem_q  [MAX_DIGITS];
  logic [DIGIT_W-1:0] second_mem_q [MAX_DIGITS];
  logic [DIGIT_W-1:0] a_q, b_q;
  logic [LW-1:0]      first_len_q, second_len_q;
  opnd_stat_t         stat_q;

  logic [DIGIT_W-1:0] dig_sat;
  logic               first_room, second_room;
  logic               wr_first, wr_second, drop;

  assign dig_sat     = (wr_i.digit > DIGIT_MAX) ? DIGIT_MAX : wr_i.digit;
  assign first_room  = first_len_q < LW'(MAX_DIGITS);
  assign second_room = second_len_q < LW'(MAX_DIGITS);
  assign wr_first    = wr_i.en && (wr_i.sel == CMD_FIRST) && first_room;
  assign wr_second   = wr_i.en && (wr_i.sel == CMD_SECOND) && second_room;
  assign drop        = wr_i.en && !wr_first && !wr_second;

  always_ff @(posedge clk_i) begin
    if (wr_first) first_mem_q[first_len_q[AW-1:0]] <= dig_sat;
    if (wr_second) second_mem_q[second_len_q[AW-1:0]] <= dig_sat;
    if (rd_en_i) begin
      a_q <= first_mem_q[rd_a_addr_i];
      b_q <= second_mem_q[rd_b_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_len_q  <= '0;
      second_len_q <= '0;
      stat_q       <= '0;
    end else if (clear_i) begin
      first_len_q     <= '0;
      second_len_q    <= '0;
      stat_q.overflow <= 1'b0;
    end else begin
      if (wr_first) begin
        first_len_q <= first_len_q + LW'(1);
        if (first_len_q == '0) stat_q.first_zero <= (dig_sat == DIGIT_ZERO);
      end
      if (wr_second) begin
        second_len_q <= second_len_q + LW'(1);
        if (second_len_q == '0) stat_q.second_zero <= (dig_sat == DIGIT_ZERO);
      end
      if (drop) stat_q.overflow <= 1'b1;
    end
  end

  assign a_digit_o    = a_q;
  assign b_digit_o    = b_q;
  assign first_len_o  = first_len_q;
  assign second_len_o = second_len_q;
  assign stat_o       = stat_q;

endmodule

/* hw/rtl/dsm_column_unit.sv */
// Column sum memory with its read-modify-write stage and carry ripple.
module dsm_column_unit import dsm_pkg::*; #(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF,
  localparam int unsigned COLS = 2 * MAX_DIGITS,
  localparam int unsigned CW   = $clog2(COLS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  col_cmd_t           cmd_i,
  input  logic [CW-1:0]      addr_i,
  input  logic [PROD_W-1:0]  prod_i,
  output logic [DIGIT_W-1:0] digit_o,
  output logic               lead_zero_o
);

  logic [SUM_W-1:0] mem_q [COLS];
  logic [SUM_W-1:0] rdata_q;
  col_cmd_t         s1_q;
  logic [CW-1:0]    s1_addr_q;
  logic [SUM_W-1:0] carry_q;
  logic             fwd_hit_q;
  logic [SUM_W-1:0] fwd_data_q;
  logic             lead_zero_q;

  logic             reading, s1_wr, we;
  logic [CW-1:0]    waddr;
  logic [SUM_W-1:0] base, rip_sum, quot, rem, s1_data, wdata;

  assign reading = (cmd_i.op == COL_ACC) || (cmd_i.op == COL_RIPPLE) ||
                   (cmd_i.op == COL_READ);
  assign s1_wr   = (s1_q.op == COL_ACC) || (s1_q.op == COL_RIPPLE);

  // write of the previous cycle lands too late for the memory read
  assign base    = fwd_hit_q ? fwd_data_q : rdata_q;
  assign rip_sum = base + (s1_q.first ? '0 : carry_q);
  assign quot    = div10(rip_sum);
  assign rem     = rip_sum - ((quot << 3) + (quot << 1));

  always_comb begin
    s1_data = base + SUM_W'(prod_i);
    if (s1_q.op == COL_RIPPLE) s1_data = s1_q.msb ? rip_sum : rem;
  end

  always_comb begin
    we    = 1'b0;
    waddr = addr_i;
    wdata = '0;
    if (s1_wr) begin
      we    = 1'b1;
      waddr = s1_addr_q;
      wdata = s1_data;
    end else if (cmd_i.op == COL_CLEAR) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (reading) rdata_q <= mem_q[addr_i];
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q  <= addr_i;
    fwd_data_q <= wdata;
    if (s1_q.op == COL_RIPPLE) carry_q <= quot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= '{op: COL_IDLE, first: 1'b0, msb: 1'b0};
      fwd_hit_q   <= 1'b0;
      lead_zero_q <= 1'b0;
    end else begin
      s1_q      <= cmd_i;
      fwd_hit_q <= s1_wr && reading && (s1_addr_q == addr_i);
      if ((s1_q.op == COL_RIPPLE) && s1_q.msb) lead_zero_q <= (rip_sum == '0);
    end
  end

  assign digit_o     = base[DIGIT_W-1:0];
  assign lead_zero_o = lead_zero_q;

  a_ripple_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_q.op == COL_RIPPLE) && !s1_q.msb |-> rem < RADIX)
    else $error("ripple left a column at ten or above");

  a_clear_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == COL_CLEAR) |-> !s1_wr)
    else $error("clear collides with a pending column write");

  a_read_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_q.op == COL_READ) |-> base < RADIX)
    else $error("emitted column is not a decimal digit");

endmodule

/* tb/dsm_product_checker.sv */
// Monitor and predictor for the decimal string multiplier digit and product channels.
module dsm_product_checker import dsm_pkg::*; #(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  dsm_in_if    in_mon,
  dsm_out_if   out_mon,
  output int   fail_cnt_o,
  output int   pending_o
);

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               last;
    logic               too_long;
  } prod_digit_t;

  logic [DIGIT_W-1:0] opnd_a [MAX_DIGITS];
  logic [DIGIT_W-1:0] opnd_b [MAX_DIGITS];
  int unsigned        len_a;
  int unsigned        len_b;
  bit                 dropped;
  prod_digit_t        awaited_digits[$];

  // Stores one digit; on the final flag pushes every product digit of the run.
  function automatic void load_and_multiply(logic cmd, logic [DIGIT_W-1:0] dig, logic fin);
    logic [DIGIT_W-1:0] d;
    int unsigned        sums [2*MAX_DIGITS];
    int unsigned        total;
    int unsigned        start;
    bit                 zero;
    prod_digit_t        rec;
    d = (dig > DIGIT_MAX) ? DIGIT_MAX : dig;
    if (cmd == CMD_FIRST) begin
      if (len_a < MAX_DIGITS) begin
        opnd_a[len_a] = d;
        len_a++;
      end else
        dropped = 1'b1;
    end else begin
      if (len_b < MAX_DIGITS) begin
        opnd_b[len_b] = d;
        len_b++;
      end else
        dropped = 1'b1;
    end
    if (!fin) return;

    zero = (len_a == 0) || (len_b == 0) ||
           (len_a == 1 && opnd_a[0] == DIGIT_ZERO) ||
           (len_b == 1 && opnd_b[0] == DIGIT_ZERO);
    if (zero) begin
      rec = '{digit: DIGIT_ZERO, last: 1'b1, too_long: dropped};
      awaited_digits.push_back(rec);
    end else begin
      total = len_a + len_b;
      foreach (sums[k]) sums[k] = 0;
      for (int unsigned i = 0; i < len_a; i++)
        for (int unsigned j = 0; j < len_b; j++)
          sums[i + j + 1] += opnd_a[i] * opnd_b[j];
      // carry ripple, least significant column first
      for (int unsigned k = total - 1; k > 0; k--) begin
        sums[k - 1] += sums[k] / 10;
        sums[k] = sums[k] % 10;
      end
      start = (sums[0] == 0) ? 1 : 0;
      for (int unsigned k = start; k < total; k++) begin
        rec = '{digit: DIGIT_W'(sums[k]), last: (k == total - 1), too_long: dropped};
        awaited_digits.push_back(rec);
      end
    end
    len_a   = 0;
    len_b   = 0;
    dropped = 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    prod_digit_t exp_d;
    if (!rst_ni) begin
      len_a      = 0;
      len_b      = 0;
      dropped    = 1'b0;
      awaited_digits.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_digits.size() == 0) begin
          $error("product transfer with nothing expected: digit %0d last %0b too_long %0b",
                 out_mon.product_digit, out_mon.last_digit, out_mon.too_long);
          fail_cnt_o++;
        end else begin
          exp_d = awaited_digits.pop_front();
          if (out_mon.product_digit !== exp_d.digit) begin
            $error("product_digit: expected %0d, actual %0d", exp_d.digit,
                   out_mon.product_digit);
            fail_cnt_o++;
          end
          if (out_mon.last_digit !== exp_d.last) begin
            $error("last_digit: expected %0b, actual %0b", exp_d.last, out_mon.last_digit);
            fail_cnt_o++;
          end
          if (out_mon.too_long !== exp_d.too_long) begin
            $error("too_long: expected %0b, actual %0b", exp_d.too_long, out_mon.too_long);
            fail_cnt_o++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        load_and_multiply(in_mon.command, in_mon.digit, in_mon.final_digit);
      pending_o = awaited_digits.size();
    end
  end

endmodule

/* tb/tb_decimal_string_multiplier.sv */
// Stimulus, stall patterns and verdict for the decimal string multiplier.
module tb_decimal_string_multiplier;
  import dsm_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned HOLD_CYCLES   = 400;  // long receiver hold-off
  localparam int unsigned SETTLE_CYCLES = 40;   // quiet time after the last product digit
  localparam int unsigned TOTAL_ITEMS   = 130;  // random runs start until this many digit transfers

  logic clk;
  logic rst_n;

  dsm_in_if  digit_ch ();
  dsm_out_if prod_ch ();

  int          fail_cnt;
  int          pending_cnt;
  int unsigned items_sent;
  int          burst_left;
  bit          hold_req;   // set by stimulus, cleared by the receiver once the hold is over

  decimal_string_multiplier dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (digit_ch),
    .out_o  (prod_ch)
  );

  dsm_product_checker checker_i (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_mon     (digit_ch),
    .out_mon    (prod_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a missing product digit ends here.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: windows of random length, each with its own stall rate (zero included),
  // plus one long hold-off on request so the block backs up into its digit input.
  initial begin : rx_stall
    int window_left;
    int stall_pct;
    window_left = 0;
    stall_pct   = 0;
    prod_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        prod_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (window_left == 0) begin
          window_left = $urandom_range(4, 64);
          case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 25;
            2:       stall_pct = 60;
            default: stall_pct = 90;
          endcase
        end
        window_left--;
        prod_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // One digit transfer. Bursts of random length; between bursts valid drops for a
  // random gap (sometimes none) with junk on the payload.
  task automatic send_digit(input logic cmd, input logic [DIGIT_W-1:0] dig, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        digit_ch.valid       <= 1'b0;
        digit_ch.command     <= 1'($urandom);
        digit_ch.digit       <= DIGIT_W'($urandom);
        digit_ch.final_digit <= 1'($urandom);
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    digit_ch.valid       <= 1'b1;
    digit_ch.command     <= cmd;
    digit_ch.digit       <= dig;
    digit_ch.final_digit <= fin;
    @(posedge clk);
    while (!digit_ch.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Sender pause: nothing offered until every awaited product digit has come out.
  task automatic drain_products();
    digit_ch.valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending_cnt != 0);
  endtask

  // Well formed run: first operand, then second, final flag on the last digit sent.
  // With an empty second operand the flag rides on the last first-operand digit.
  // Styles: 0 any nibble, 1 nines and saturating nibbles, 2 two leading zeros.
  task automatic run_product(input int n_first, input int n_second, input int style);
    logic [DIGIT_W-1:0] dig;
    for (int i = 0; i < n_first + n_second; i++) begin
      case (style)
        1:       dig = DIGIT_W'($urandom_range(9, 15));
        2:       dig = (i == 0 || i == 1) ? DIGIT_ZERO : DIGIT_W'($urandom_range(0, 9));
        default: dig = DIGIT_W'($urandom_range(0, 15));
      endcase
      if (i < n_first)
        send_digit(CMD_FIRST, dig, (n_second == 0) && (i == n_first - 1));
      else
        send_digit(CMD_SECOND, dig, i == n_first + n_second - 1);
    end
  endtask

  // Noise: operands interleaved at random, final flag on a random operand.
  task automatic run_mixed(input int n);
    for (int i = 0; i < n; i++) begin
      send_digit(($urandom_range(0, 1) == 0) ? CMD_FIRST : CMD_SECOND,
                 DIGIT_W'($urandom_range(0, 15)), i == n - 1);
    end
  endtask

  initial begin : stimulus
    int kind;
    int n_pre;
    bit hold_issued;
    hold_issued = 1'b0;
    items_sent  = 0;
    burst_left  = 0;
    hold_req    = 1'b0;
    rst_n       = 1'b0;
    digit_ch.valid       <= 1'b0;
    digit_ch.command     <= CMD_FIRST;
    digit_ch.digit       <= DIGIT_ZERO;
    digit_ch.final_digit <= 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // --- directed ---
    send_digit(CMD_FIRST, 4'd9, 1'b0);  // 9 x 9
    send_digit(CMD_SECOND, 4'd9, 1'b1);
    send_digit(CMD_SECOND, 4'd5, 1'b1);  // empty first operand
    send_digit(CMD_FIRST, 4'd7, 1'b1);   // final on first operand, second empty
    send_digit(CMD_FIRST, DIGIT_ZERO, 1'b0);  // single zero times 4
    send_digit(CMD_SECOND, 4'd4, 1'b1);
    send_digit(CMD_FIRST, 4'd4, 1'b0);   // 4 times single zero
    send_digit(CMD_SECOND, DIGIT_ZERO, 1'b1);
    send_digit(CMD_FIRST, DIGIT_ZERO, 1'b0);  // "00" x 5 keeps one leading zero
    send_digit(CMD_FIRST, DIGIT_ZERO, 1'b0);
    send_digit(CMD_SECOND, 4'd5, 1'b1);
    send_digit(CMD_FIRST, 4'd15, 1'b0);  // nibbles above nine saturate: 99 x 9
    send_digit(CMD_FIRST, 4'd12, 1'b0);
    send_digit(CMD_SECOND, 4'd10, 1'b1);
    send_digit(CMD_SECOND, 4'd3, 1'b0);  // operands interleaved, final on first operand
    send_digit(CMD_FIRST, 4'd4, 1'b1);
    send_digit(CMD_FIRST, 4'd3, 1'b0);   // 3 x 3: leading zero column dropped
    send_digit(CMD_SECOND, 4'd3, 1'b1);
    send_digit(CMD_FIRST, 4'd5, 1'b0);   // 5 x 20: carry into the top column
    send_digit(CMD_SECOND, 4'd2, 1'b0);
    send_digit(CMD_SECOND, DIGIT_ZERO, 1'b0 | 1'b1);

    // sender waits for the block to empty completely
    drain_products();

    // Extreme: 33 first-operand digits (one dropped, too_long set) times 32 nines:
    // largest column sums and the full 64 digit product.
    run_product(33, 32, 1);

    // --- random ---
    while (items_sent < TOTAL_ITEMS) begin
      if (!hold_issued && items_sent >= 50) begin
        // receiver holds off while the sender keeps offering several products
        hold_issued = 1'b1;
        hold_req    = 1'b1;
      end
      kind = $urandom_range(0, 19);
      if (kind < 11)
        run_product($urandom_range(1, 5), $urandom_range(1, 5), $urandom_range(0, 2) == 0);
      else if (kind < 13)
        run_product($urandom_range(1, 12), $urandom_range(1, 12), 0);
      else if (kind == 13)
        run_product($urandom_range(1, 3), $urandom_range(29, 34), $urandom_range(0, 1));
      else if (kind == 14)
        run_product($urandom_range(29, 34), $urandom_range(0, 3), $urandom_range(0, 1));
      else if (kind == 15)
        run_product(0, $urandom_range(1, 4), 0);  // empty first operand
      else if (kind == 16)
        run_product($urandom_range(1, 4), 0, 0);  // empty second operand
      else if (kind == 17) begin
        // single zero on one side
        if ($urandom_range(0, 1) == 0) begin
          send_digit(CMD_FIRST, DIGIT_ZERO, 1'b0);
          run_product(0, $urandom_range(1, 4), 0);
        end else begin
          n_pre = $urandom_range(1, 4);
          for (int i = 0; i < n_pre; i++)
            send_digit(CMD_FIRST, DIGIT_W'($urandom_range(0, 15)), 1'b0);
          send_digit(CMD_SECOND, DIGIT_ZERO, 1'b1);
        end
      end else if (kind == 18)
        run_product($urandom_range(2, 5), $urandom_range(1, 4), 2);
      else
        run_mixed($urandom_range(1, 8));
    end

    // wait for the last product, then a quiet stretch for anything stray
    digit_ch.valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_cnt == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/dsm_pkg.sv
hw/rtl/dsm_stream_if.sv
hw/rtl/dsm_operand_store.sv
hw/rtl/dsm_column_unit.sv
hw/rtl/decimal_string_multiplier.sv
tb/dsm_product_checker.sv
tb/tb_decimal_string_multiplier.sv
